// ===== rtl/core/cls_pkg.sv =====
// ============================================================================
// cls_pkg: shared types and constants of the connector latch supervisor
// Holds field widths, reset values of the setup registers, register indexes
// and the structs that carry setup to the lanes and reports to the merge.
// ============================================================================
package cls_pkg;

    // Default number of latches supervised.
    localparam int LATCH_COUNT_DEF = 4;

    // Widths of the beat fields; latches beyond the field width are not seen.
    localparam int FIELD_W = 4;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;
    localparam int TICK_W  = 9;
    localparam int STRAY_W = 8;

    // Register indexes on the setup port.
    localparam logic [IDX_W-1:0] CFG_RELEASE_TIMEOUT = 2'd0;
    localparam logic [IDX_W-1:0] CFG_BAD_LOCK_LIMIT  = 2'd1;

    // Reset values of the setup registers.
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 8'd100;
    localparam logic [CFG_W-1:0] LIMIT_RESET   = 8'd100;

    typedef struct packed {
        logic [CFG_W-1:0] release_timeout;
        logic [CFG_W-1:0] bad_lock_limit;
    } t_cfg;

    // What one lane reports for the tick it just processed.
    typedef struct packed {
        logic lock_cmd;
        logic unlock_cmd;
        logic locked;
        logic pending;
        logic bad;
    } t_lane_res;

endpackage

// ===== rtl/core/connector_latch_supervisor_top.sv =====
// ============================================================================
// connector_latch_supervisor_top: docking latch supervisor
// Each result beat is registered in the output register or the skid entry.
// Throughput: one beat per cycle while the skid entry is free; each latch
// lane ends a tick in the cycle its beat is accepted, so the next may follow.
// Reset (synchronous, active low): all latches unlocked, counters cleared,
// output and skid entries empty, both setup registers back to 100.
// ============================================================================
//
// Structure
//   One cls_lane per latch holds that latch's flags and counters and computes
//   its tick. Release requests are settled by cls_grant, which looks at the
//   lane state from before the tick and picks the lowest locked latch that is
//   not yet releasing. cls_merge packs the lane reports into the output beat
//   and buffers it in an output register with one skid entry, so an input
//   beat is still taken while one finished result waits downstream.
//
// Setup registers
//   The release timeout and the bad lock limit are written through a plain
//   write port; an index beyond the two registers is ignored.
module connector_latch_supervisor_top
    import cls_pkg::*;
#(
    parameter int LATCH_COUNT = LATCH_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FIELD_W-1:0] i_presence_mask,
    input  logic               i_release_request,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FIELD_W-1:0] o_lock_command,
    output logic [FIELD_W-1:0] o_unlock_command,
    output logic [FIELD_W-1:0] o_locked_mask,
    output logic [FIELD_W-1:0] o_releasing_mask,
    output logic [FIELD_W-1:0] o_bad_position_mask,

    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    t_cfg                   r_cfg;
    logic                   step;
    logic                   buf_full;
    logic [LATCH_COUNT-1:0] candidate;
    logic [LATCH_COUNT-1:0] grant;
    t_lane_res              lane_res [LATCH_COUNT];

    // Setup registers: the user must write only while idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_timeout <= TIMEOUT_RESET;
            r_cfg.bad_lock_limit  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RELEASE_TIMEOUT: r_cfg.release_timeout <= i_cfg_data;
                CFG_BAD_LOCK_LIMIT:  r_cfg.bad_lock_limit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // An input beat is taken whenever the skid entry is free.
    assign o_in_ready = !buf_full;
    assign step       = i_in_valid && o_in_ready;

    cls_grant #(
        .LATCH_COUNT (LATCH_COUNT)
    ) u_grant (
        .i_request   (i_release_request),
        .i_candidate (candidate),
        .o_grant     (grant)
    );

    for (genvar g = 0; g < LATCH_COUNT; g++) begin : g_lane
        logic present;

        // Latches beyond the presence field never sense a partner.
        if (g < FIELD_W) begin : g_seen
            assign present = i_presence_mask[g];
        end else begin : g_unseen
            assign present = 1'b0;
        end

        cls_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_step      (step),
            .i_present   (present),
            .i_grant     (grant[g]),
            .i_cfg       (r_cfg),
            .o_candidate (candidate[g]),
            .o_res       (lane_res[g])
        );
    end

    cls_merge #(
        .LATCH_COUNT (LATCH_COUNT)
    ) u_merge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (step),
        .i_res               (lane_res),
        .i_out_ready         (i_out_ready),
        .o_full              (buf_full),
        .o_out_valid         (o_out_valid),
        .o_lock_command      (o_lock_command),
        .o_unlock_command    (o_unlock_command),
        .o_locked_mask       (o_locked_mask),
        .o_releasing_mask    (o_releasing_mask),
        .o_bad_position_mask (o_bad_position_mask)
    );

endmodule

// ===== rtl/core/cls_lane.sv =====
// ============================================================================
// cls_lane: state and tick logic of one docking latch
// Keeps the locked and pending flags and both counters of one latch and
// advances them by one tick on each accepted beat.
// ============================================================================
module cls_lane
    import cls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic      i_present,
    input  logic      i_grant,
    input  t_cfg      i_cfg,
    output logic      o_candidate,
    output t_lane_res o_res
);

    logic               r_locked, n_locked;
    logic               r_pend, n_pend;
    logic [TICK_W-1:0]  r_ticks, n_ticks;
    logic [STRAY_W-1:0] r_stray, n_stray;

    logic               pend0, lock_now, locked1, free_now;
    logic               pend1, locked2, bad_now;
    logic [STRAY_W:0]   stray_inc;

    // A latch may take a release request when locked and not yet releasing.
    assign o_candidate = r_locked && !r_pend;

    always_comb begin
        pend0    = r_pend | i_grant;
        lock_now = !pend0 && i_present && !r_locked;
        locked1  = r_locked | lock_now;

        free_now = pend0 && ((!i_present && locked1) ||
                             (r_ticks > {1'b0, i_cfg.release_timeout}));
        pend1    = pend0 && !free_now;
        locked2  = locked1 && !free_now;

        if (pend0) begin
            n_ticks = free_now ? TICK_W'(1) : TICK_W'(r_ticks + TICK_W'(1));
        end else begin
            n_ticks = '0;
        end

        stray_inc = {1'b0, r_stray} + (STRAY_W+1)'(1);
        bad_now   = 1'b0;
        n_pend    = pend1;
        if (locked2 && !i_present) begin
            if (stray_inc > {1'b0, i_cfg.bad_lock_limit}) begin
                n_stray = '0;
                n_pend  = 1'b1;
                bad_now = 1'b1;
            end else begin
                n_stray = stray_inc[STRAY_W-1:0];
            end
        end else begin
            n_stray = '0;
        end
        n_locked = locked2;

        o_res.lock_cmd   = lock_now;
        o_res.unlock_cmd = pend0 && locked1;
        o_res.locked     = n_locked;
        o_res.pending    = n_pend;
        o_res.bad        = bad_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b0;
            r_pend   <= 1'b0;
            r_ticks  <= '0;
            r_stray  <= '0;
        end else if (i_step) begin
            r_locked <= n_locked;
            r_pend   <= n_pend;
            r_ticks  <= n_ticks;
            r_stray  <= n_stray;
        end
    end

endmodule

// ===== rtl/core/cls_grant.sv =====
// ============================================================================
// cls_grant: release request arbiter
// Hands a release request to the lowest-numbered candidate latch.
// ============================================================================
module cls_grant
    import cls_pkg::*;
#(
    parameter int LATCH_COUNT = LATCH_COUNT_DEF
) (
    input  logic                   i_request,
    input  logic [LATCH_COUNT-1:0] i_candidate,
    output logic [LATCH_COUNT-1:0] o_grant
);

    // Isolate the lowest set bit of the candidate vector.
    assign o_grant = i_request ? (i_candidate & (~i_candidate + LATCH_COUNT'(1)))
                               : '0;

endmodule

// ===== rtl/core/cls_merge.sv =====
// ============================================================================
// cls_merge: result packing and output buffering
// Packs the lane reports into the beat fields and holds them in an output
// register backed by one skid entry.
// ============================================================================
module cls_merge
    import cls_pkg::*;
#(
    parameter int LATCH_COUNT = LATCH_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_lane_res          i_res [LATCH_COUNT],
    input  logic               i_out_ready,
    output logic               o_full,
    output logic               o_out_valid,
    output logic [FIELD_W-1:0] o_lock_command,
    output logic [FIELD_W-1:0] o_unlock_command,
    output logic [FIELD_W-1:0] o_locked_mask,
    output logic [FIELD_W-1:0] o_releasing_mask,
    output logic [FIELD_W-1:0] o_bad_position_mask
);

    localparam int BEAT_W = 5 * FIELD_W;

    logic [FIELD_W-1:0] lock_v, unlock_v, locked_v, pend_v, bad_v;
    logic [BEAT_W-1:0]  beat;
    logic [BEAT_W-1:0]  r_out, r_skid;
    logic               r_out_valid, r_skid_valid;
    logic               take;

    for (genvar g = 0; g < FIELD_W; g++) begin : g_pack
        if (g < LATCH_COUNT) begin : g_on
            assign lock_v[g]   = i_res[g].lock_cmd;
            assign unlock_v[g] = i_res[g].unlock_cmd;
            assign locked_v[g] = i_res[g].locked;
            assign pend_v[g]   = i_res[g].pending;
            assign bad_v[g]    = i_res[g].bad;
        end else begin : g_off
            assign lock_v[g]   = 1'b0;
            assign unlock_v[g] = 1'b0;
            assign locked_v[g] = 1'b0;
            assign pend_v[g]   = 1'b0;
            assign bad_v[g]    = 1'b0;
        end
    end

    assign beat = {lock_v, unlock_v, locked_v, pend_v, bad_v};
    assign take = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_push) begin
                if (!r_out_valid || take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= beat;
            end else begin
                r_skid <= beat;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_full              = r_skid_valid;
    assign o_out_valid         = r_out_valid;
    assign o_lock_command      = r_out[5*FIELD_W-1:4*FIELD_W];
    assign o_unlock_command    = r_out[4*FIELD_W-1:3*FIELD_W];
    assign o_locked_mask       = r_out[3*FIELD_W-1:2*FIELD_W];
    assign o_releasing_mask    = r_out[2*FIELD_W-1:FIELD_W];
    assign o_bad_position_mask = r_out[FIELD_W-1:0];

endmodule

// ===== rtl/core/cls_checker.sv =====
// ============================================================================
// cls_checker: port checks of the connector latch supervisor
// Watches the top level's output beats for mask consistency and stalls.
// ============================================================================
module cls_checker
    import cls_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [FIELD_W-1:0] o_lock_command,
    input logic [FIELD_W-1:0] o_unlock_command,
    input logic [FIELD_W-1:0] o_locked_mask,
    input logic [FIELD_W-1:0] o_releasing_mask,
    input logic [FIELD_W-1:0] o_bad_position_mask
);

    // A stalled result beat stays up and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
            $stable(o_lock_command) && $stable(o_unlock_command) &&
            $stable(o_locked_mask) && $stable(o_releasing_mask) &&
            $stable(o_bad_position_mask))
        else $error("result beat changed while stalled");

    // Lock is only driven on a latch that is not releasing, unlock only on one that is.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lock_command & o_unlock_command) == '0)
        else $error("lock and unlock driven on the same latch");

    // A latch that was just locked ends the tick locked.
    a_lock_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lock_command & ~o_locked_mask) == '0)
        else $error("locked latch not reported as locked");

    // A forced release leaves the latch locked and releasing.
    a_bad_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bad_position_mask & ~(o_releasing_mask & o_locked_mask)) == '0)
        else $error("forced release without a locked, releasing latch");

endmodule

bind connector_latch_supervisor_top cls_checker u_cls_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_lock_command      (o_lock_command),
    .o_unlock_command    (o_unlock_command),
    .o_locked_mask       (o_locked_mask),
    .o_releasing_mask    (o_releasing_mask),
    .o_bad_position_mask (o_bad_position_mask)
);
